[hw/rtl/lre_pkg.sv]
package lre_pkg;

	// Field and state widths
	localparam int CH_W     = 8;
	localparam int RUN_W    = 16;
	localparam int THR_W    = 5;
	localparam int DIGITS   = 5;
	localparam int DIG_IDX_W = $clog2(DIGITS + 1);

	// Defaults for top-level parameters
	localparam int MAX_RUN_DEF   = 65535;
	localparam int CMD_DEPTH_DEF = 4;

	// Threshold register reset and clamp bounds
	localparam logic [THR_W-1:0] THR_RESET = 5'd3;
	localparam logic [THR_W-1:0] THR_MIN   = 5'd2;
	localparam logic [THR_W-1:0] THR_MAX   = 5'd12;

	// ASCII codes
	localparam logic [CH_W-1:0] ASCII_ZERO = 8'h30;
	localparam logic [CH_W-1:0] ASCII_UA   = 8'h41;
	localparam logic [CH_W-1:0] ASCII_UZ   = 8'h5A;
	localparam logic [CH_W-1:0] ASCII_LA   = 8'h61;
	localparam logic [CH_W-1:0] ASCII_LZ   = 8'h7A;

	// Reciprocal of ten: floor(v / 10) == (v * RECIP10) >> RECIP_SH for 16-bit v
	localparam logic [RUN_W-1:0] RECIP10  = 16'd52429;
	localparam int               RECIP_SH = 19;

	// Flush command from front to back
	typedef struct packed {
		logic [CH_W-1:0]  letter;
		logic [RUN_W-1:0] len;
		logic             done;   // last command of the stream
		logic             bare;   // end marker with no bytes
	} cmd_t;

	function automatic logic is_letter(input logic [CH_W-1:0] c);
		is_letter = ((c >= ASCII_UA) && (c <= ASCII_UZ)) ||
			((c >= ASCII_LA) && (c <= ASCII_LZ));
	endfunction

endpackage

[hw/rtl/letter_run_length_encoder_core.sv]
// Run-length encoder for the letters A-Z and a-z of a byte stream. Bytes go in
// through push/full; encoded bytes come out through empty/pop, one byte per
// transfer, with stream_done on the last byte of each stream (a stream with no
// letters ends with one item that has byte_valid low). A run shorter than the
// threshold register comes out as repeated letters, any other as its decimal
// length followed by the letter. The front takes one byte per cycle while the
// command FIFO has room, stalls for a second command when a letter change falls
// on the end-of-stream byte, and queues flush commands for the back. The back
// sets the rate: one command at a time, a count converted to decimal digits
// (at most five), then one output byte per cycle while popped. The threshold
// is clamped to 2..12 and may only be written while no bytes are in flight.
module letter_run_length_encoder_core #(
	parameter int MAX_RUN   = lre_pkg::MAX_RUN_DEF,
	parameter int CMD_DEPTH = lre_pkg::CMD_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [lre_pkg::CH_W-1:0]  ch,
	input  logic                      end_of_stream,
	output logic                      empty,
	input  logic                      pop,
	output logic [lre_pkg::CH_W-1:0]  out_byte,
	output logic                      byte_valid,
	output logic                      stream_done,
	input  logic                      cfg_we,
	input  logic [lre_pkg::THR_W-1:0] cfg_data
);

	logic [lre_pkg::THR_W-1:0] thr_q;
	logic                      cmd_wr;
	logic                      cmd_full;
	logic                      cmd_rd;
	logic                      cmd_empty;
	lre_pkg::cmd_t             cmd_in;
	lre_pkg::cmd_t             cmd_out;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= lre_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	lre_front #(
		.MAX_RUN(MAX_RUN)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.ch           (ch),
		.end_of_stream(end_of_stream),
		.cmd_wr       (cmd_wr),
		.cmd_data     (cmd_in),
		.cmd_full     (cmd_full)
	);

	lre_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wr_data(cmd_in),
		.full   (cmd_full),
		.rd     (cmd_rd),
		.rd_data(cmd_out),
		.empty  (cmd_empty)
	);

	lre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.thr        (thr_q),
		.cmd_empty  (cmd_empty),
		.cmd_data   (cmd_out),
		.cmd_rd     (cmd_rd),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.stream_done(stream_done)
	);

endmodule

[hw/rtl/lre_cmd_fifo.sv]
module lre_cmd_fifo #(
	parameter int DEPTH = lre_pkg::CMD_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  lre_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd,
	output lre_pkg::cmd_t rd_data,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lre_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/lre_front.sv]
module lre_front #(
	parameter int MAX_RUN = lre_pkg::MAX_RUN_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [lre_pkg::CH_W-1:0] ch,
	input  logic                     end_of_stream,
	output logic                     cmd_wr,
	output lre_pkg::cmd_t            cmd_data,
	input  logic                     cmd_full
);

	localparam logic [lre_pkg::RUN_W-1:0] MAX_LEN = lre_pkg::RUN_W'(MAX_RUN);

	logic [lre_pkg::CH_W-1:0]  letter_q;
	logic [lre_pkg::RUN_W-1:0] len_q;
	logic                      active_q;
	logic                      pend_v_q;
	lre_pkg::cmd_t             pend_q;

	logic [lre_pkg::CH_W-1:0]  letter_d;
	logic [lre_pkg::RUN_W-1:0] len_d;
	logic [lre_pkg::RUN_W-1:0] len_inc;
	logic                      active_d;
	logic                      pend_v_d;
	lre_pkg::cmd_t             pend_d;
	logic                      accept;
	logic                      is_let;
	logic                      same;

	// A held second command of a step, or a full command FIFO, holds off the next transfer
	assign full    = pend_v_q || cmd_full;
	assign accept  = push && !full;
	assign is_let  = lre_pkg::is_letter(ch);
	assign same    = active_q && (ch == letter_q);
	assign len_inc = len_q + 1'b1;

	// Classify the byte and build flush commands
	always_comb begin
		letter_d = letter_q;
		len_d    = len_q;
		active_d = active_q;
		pend_v_d = pend_v_q;
		pend_d   = pend_q;
		cmd_wr   = 1'b0;
		cmd_data = '{letter: letter_q, len: len_q, done: 1'b0, bare: 1'b0};
		if (pend_v_q) begin
			if (!cmd_full) begin
				cmd_wr   = 1'b1;
				cmd_data = pend_q;
				pend_v_d = 1'b0;
			end
		end else if (accept) begin
			if (is_let && same) begin
				len_d = len_inc;
				if (len_inc >= MAX_LEN) begin
					// Run hits the maximum: flush it now
					cmd_wr   = 1'b1;
					cmd_data = '{letter: letter_q, len: len_inc, done: end_of_stream,
						bare: 1'b0};
					active_d = 1'b0;
					len_d    = '0;
				end else if (end_of_stream) begin
					cmd_wr   = 1'b1;
					cmd_data = '{letter: letter_q, len: len_inc, done: 1'b1, bare: 1'b0};
				end
			end else if (is_let) begin
				letter_d = ch;
				len_d    = lre_pkg::RUN_W'(1);
				active_d = 1'b1;
				if (active_q) begin
					// Letter change flushes the old run
					cmd_wr   = 1'b1;
					cmd_data = '{letter: letter_q, len: len_q, done: 1'b0, bare: 1'b0};
					if (end_of_stream) begin
						pend_v_d = 1'b1;
						pend_d   = '{letter: ch, len: lre_pkg::RUN_W'(1), done: 1'b1,
							bare: 1'b0};
					end
				end else if (end_of_stream) begin
					cmd_wr   = 1'b1;
					cmd_data = '{letter: ch, len: lre_pkg::RUN_W'(1), done: 1'b1, bare: 1'b0};
				end
			end else if (end_of_stream) begin
				// Non-letter end: flush pending run or send a bare marker
				cmd_wr   = 1'b1;
				cmd_data = '{letter: letter_q, len: len_q, done: 1'b1, bare: !active_q};
			end
			if (end_of_stream) begin
				letter_d = '0;
				len_d    = '0;
				active_d = 1'b0;
			end
		end
	end

	// Run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q <= '0;
			len_q    <= '0;
			active_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			letter_q <= letter_d;
			len_q    <= len_d;
			active_q <= active_d;
			pend_v_q <= pend_v_d;
		end
	end

	// Held second command, payload only
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
	end

endmodule

[hw/rtl/lre_back.sv]
module lre_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [lre_pkg::THR_W-1:0] thr,
	input  logic                      cmd_empty,
	input  lre_pkg::cmd_t             cmd_data,
	output logic                      cmd_rd,
	output logic                      empty,
	input  logic                      pop,
	output logic [lre_pkg::CH_W-1:0]  out_byte,
	output logic                      byte_valid,
	output logic                      stream_done
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BARE = 3'd1;
	localparam logic [2:0] ST_REP  = 3'd2;
	localparam logic [2:0] ST_CONV = 3'd3;
	localparam logic [2:0] ST_DIG  = 3'd4;
	localparam logic [2:0] ST_LET  = 3'd5;

	localparam int PROD_W = 2 * lre_pkg::RUN_W;

	logic [2:0]                    st_q;
	logic [lre_pkg::CH_W-1:0]      let_q;
	logic [lre_pkg::RUN_W-1:0]     cnt_q;
	logic                          done_q;
	logic [3:0]                    dig_q [lre_pkg::DIGITS];
	logic [lre_pkg::DIG_IDX_W-1:0] nd_q;

	logic                          out_v_q;
	logic [lre_pkg::CH_W-1:0]      out_byte_q;
	logic                          out_bv_q;
	logic                          out_done_q;

	logic [lre_pkg::THR_W-1:0]     thr_eff;
	logic                          out_free;
	logic                          out_load;
	logic [PROD_W-1:0]             prod;
	logic [lre_pkg::RUN_W-1:0]     quo;
	logic [lre_pkg::RUN_W-1:0]     quo10;
	logic [3:0]                    rem;
	logic [lre_pkg::DIG_IDX_W-1:0] nd_m1;

	// Threshold clamped to the usable range
	always_comb begin
		if (thr < lre_pkg::THR_MIN) begin
			thr_eff = lre_pkg::THR_MIN;
		end else if (thr > lre_pkg::THR_MAX) begin
			thr_eff = lre_pkg::THR_MAX;
		end else begin
			thr_eff = thr;
		end
	end

	// One decimal digit per cycle, least significant first
	assign prod  = cnt_q * lre_pkg::RECIP10;
	assign quo   = lre_pkg::RUN_W'(prod[PROD_W-1:lre_pkg::RECIP_SH]);
	assign quo10 = (quo << 3) + (quo << 1);
	assign rem   = 4'(cnt_q - quo10);
	assign nd_m1 = nd_q - 1'b1;

	assign out_free    = !out_v_q || pop;
	assign out_load    = out_free && ((st_q == ST_BARE) || (st_q == ST_REP) ||
		(st_q == ST_DIG) || (st_q == ST_LET));
	assign cmd_rd      = (st_q == ST_IDLE) && !cmd_empty;
	assign empty       = !out_v_q;
	assign out_byte    = out_byte_q;
	assign byte_valid  = out_bv_q;
	assign stream_done = out_done_q;

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= out_load || (out_v_q && !pop);
			unique case (st_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						if (cmd_data.bare) begin
							st_q <= ST_BARE;
						end else if (cmd_data.len < lre_pkg::RUN_W'(thr_eff)) begin
							st_q <= ST_REP;
						end else begin
							st_q <= ST_CONV;
						end
					end
				end
				ST_BARE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				ST_REP: begin
					if (out_free && (cnt_q == lre_pkg::RUN_W'(1))) begin
						st_q <= ST_IDLE;
					end
				end
				ST_CONV: begin
					if (quo == '0) begin
						st_q <= ST_DIG;
					end
				end
				ST_DIG: begin
					if (out_free && (nd_q == lre_pkg::DIG_IDX_W'(1))) begin
						st_q <= ST_LET;
					end
				end
				ST_LET: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				let_q  <= cmd_data.letter;
				cnt_q  <= cmd_data.len;
				done_q <= cmd_data.done;
				nd_q   <= '0;
			end
			ST_BARE: begin
				if (out_free) begin
					out_byte_q <= '0;
					out_bv_q   <= 1'b0;
					out_done_q <= 1'b1;
				end
			end
			ST_REP: begin
				if (out_free) begin
					out_byte_q <= let_q;
					out_bv_q   <= 1'b1;
					out_done_q <= done_q && (cnt_q == lre_pkg::RUN_W'(1));
					cnt_q      <= cnt_q - 1'b1;
				end
			end
			ST_CONV: begin
				dig_q[nd_q[lre_pkg::DIG_IDX_W-1:0]] <= rem;
				nd_q  <= nd_q + 1'b1;
				cnt_q <= quo;
			end
			ST_DIG: begin
				if (out_free) begin
					out_byte_q <= lre_pkg::ASCII_ZERO + lre_pkg::CH_W'(dig_q[nd_m1]);
					out_bv_q   <= 1'b1;
					out_done_q <= 1'b0;
					nd_q       <= nd_m1;
				end
			end
			ST_LET: begin
				if (out_free) begin
					out_byte_q <= let_q;
					out_bv_q   <= 1'b1;
					out_done_q <= done_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[dv/letter_run_length_encoder_core_tb.sv]
module letter_run_length_encoder_core_tb;

	import lre_pkg::*;

	localparam int MAX_RUN_LEN = MAX_RUN_DEF;
	localparam int SETTLE      = 20;    // cycles for the front to go quiet
	localparam int STALL_LIMIT = 5000;  // cycles with no transfer before giving up

	// One encoded output byte as the block should produce it
	typedef struct packed {
		logic [CH_W-1:0] value;
		logic            valid;
		logic            done;
	} enc_byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic [CH_W-1:0]   ch = '0;
	logic              end_of_stream = 1'b0;
	logic              pop = 1'b0;
	logic              cfg_we = 1'b0;
	logic [THR_W-1:0]  cfg_data = '0;
	logic              full;
	logic              empty;
	logic [CH_W-1:0]   out_byte;
	logic              byte_valid;
	logic              stream_done;

	// Predictor state
	enc_byte_t        expected_bytes[$];
	logic [THR_W-1:0] thr_reg = THR_RESET;
	logic [CH_W-1:0]  pend_letter = '0;
	logic [RUN_W-1:0] pend_len = '0;
	bit               pend_on = 1'b0;

	int  err_count = 0;
	int  quiet_cycles = 0;
	int  pop_hold = 0;
	bit  send_idle = 1'b1;
	bit  rcv_idle = 1'b1;

	letter_run_length_encoder_core #(
		.MAX_RUN(MAX_RUN_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.ch(ch),
		.end_of_stream(end_of_stream),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.stream_done(stream_done),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------
	function automatic bit alpha_byte(input logic [CH_W-1:0] c);
		return (c >= ASCII_UA && c <= ASCII_UZ) || (c >= ASCII_LA && c <= ASCII_LZ);
	endfunction

	function automatic int clamped_thr();
		int t;
		t = int'(thr_reg);
		if (t < int'(THR_MIN)) t = int'(THR_MIN);
		if (t > int'(THR_MAX)) t = int'(THR_MAX);
		return t;
	endfunction

	function automatic void emit_byte(input logic [CH_W-1:0] b);
		expected_bytes.push_back('{value: b, valid: 1'b1, done: 1'b0});
	endfunction

	// Short runs come out as repeated letters, others as decimal count + letter
	function automatic void flush_pending();
		string digits;
		if (pend_on && pend_len != 0) begin
			if (pend_len < clamped_thr()) begin
				for (int i = 0; i < pend_len; i++) emit_byte(pend_letter);
			end else begin
				digits = $sformatf("%0d", pend_len);
				for (int i = 0; i < digits.len(); i++) emit_byte(digits[i]);
				emit_byte(pend_letter);
			end
		end
		pend_on = 1'b0;
		pend_len = '0;
	endfunction

	function automatic void predict_encoding(input logic [CH_W-1:0] c, input logic eos);
		int n0;
		n0 = expected_bytes.size();
		if (alpha_byte(c)) begin
			if (pend_on && c == pend_letter) begin
				pend_len = pend_len + 1'b1;
			end else begin
				flush_pending();
				pend_letter = c;
				pend_len = RUN_W'(1);
				pend_on = 1'b1;
			end
			if (pend_len >= MAX_RUN_LEN) flush_pending();
		end
		if (eos) begin
			flush_pending();
			// bare end marker when the stream closes with nothing written
			if (expected_bytes.size() == n0)
				expected_bytes.push_back('{value: '0, valid: 1'b0, done: 1'b1});
			else
				expected_bytes[expected_bytes.size() - 1].done = 1'b1;
			pend_letter = '0;
		end
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [CH_W-1:0] any_letter();
		if ($urandom_range(0, 1))
			return CH_W'($urandom_range(ASCII_UA, ASCII_UZ));
		return CH_W'($urandom_range(ASCII_LA, ASCII_LZ));
	endfunction

	function automatic logic [CH_W-1:0] any_nonletter();
		logic [CH_W-1:0] c;
		c = CH_W'($urandom_range(0, 255));
		while (alpha_byte(c)) c = CH_W'($urandom_range(0, 255));
		return c;
	endfunction

	// Drive one byte and hold it until the transfer happens
	task automatic send_byte(input logic [CH_W-1:0] c, input logic eos);
		int gap;
		bit ok;
		gap = send_idle ? pick_gap() : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		ch <= c;
		end_of_stream <= eos;
		ok = 1'b0;
		while (!ok) begin
			@(negedge clk);
			ok = !full;
			@(posedge clk);
		end
		predict_encoding(c, eos);
	endtask

	// Let every expected byte drain, then give the front time to settle
	task automatic drain_all();
		push <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		drain_all();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_reg = v;
	endtask

	// ---------------------------------------------------------------
	// Result side: random pop stalls, check at negedge before the transfer
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold = pop_hold - 1;
		end else begin
			pop <= 1'b1;
			if (rcv_idle && $urandom_range(0, 2) == 0) pop_hold = pick_gap();
		end
	end

	always @(negedge clk) begin
		enc_byte_t e;
		if (arst_n && pop && !empty) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected result: out_byte=%0h byte_valid=%0b stream_done=%0b",
					out_byte, byte_valid, stream_done);
				err_count++;
			end else begin
				e = expected_bytes.pop_front();
				if (out_byte !== e.value) begin
					$error("out_byte: expected %0h, got %0h", e.value, out_byte);
					err_count++;
				end
				if (byte_valid !== e.valid) begin
					$error("byte_valid: expected %0b, got %0b", e.valid, byte_valid);
					err_count++;
				end
				if (stream_done !== e.done) begin
					$error("stream_done: expected %0b, got %0b", e.done, stream_done);
					err_count++;
				end
			end
		end
	end

	// Watchdog: no transfer on either side for too long
	always @(negedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("letter_run_length_encoder_core verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Run at threshold, non-letter inside a run, run break, case change,
	// letter change on the end byte
	task automatic test_run_breaks();
		send_byte("A", 1'b0);
		send_byte("A", 1'b0);
		send_byte(".", 1'b0);
		send_byte("A", 1'b0);
		send_byte("B", 1'b0);
		send_byte("b", 1'b0);
		send_byte("b", 1'b0);
		send_byte("z", 1'b1);
	endtask

	// End marker on a non-letter with no run pending
	task automatic test_bare_end();
		send_byte("#", 1'b1);
		send_byte(8'h00, 1'b1);
	endtask

	// Bytes just outside the letter ranges, and the range ends themselves
	task automatic test_letter_edges();
		send_byte(8'h40, 1'b0);
		send_byte(ASCII_UZ, 1'b0);
		send_byte(8'h5B, 1'b0);
		send_byte(ASCII_UZ, 1'b0);
		send_byte(8'h60, 1'b0);
		send_byte(ASCII_UZ, 1'b0);
		send_byte(8'h7B, 1'b0);
		send_byte(ASCII_UZ, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(ASCII_UA, 1'b0);
		send_byte(ASCII_LA, 1'b0);
		send_byte(ASCII_LZ, 1'b1);
	endtask

	// Run long enough for a three-digit count, with a noise byte inside it,
	// ended on its own letter
	task automatic test_long_run();
		for (int k = 0; k < 104; k++) begin
			if (k == 50) send_byte(any_nonletter(), 1'b0);
			send_byte("q", 1'b0);
		end
		send_byte("q", 1'b1);
	endtask

	// Well-formed streams of random runs, with noise bytes and short streams
	task automatic random_stream_phase(input int target);
		int sent;
		int len;
		int r;
		logic [CH_W-1:0] c;
		sent = 0;
		while (sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				// fully random byte, possibly ending the stream
				send_byte(CH_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				sent++;
			end else if (r < 88) begin
				c = any_letter();
				r = $urandom_range(0, 99);
				if (r < 80) len = $urandom_range(1, 13);
				else if (r < 95) len = $urandom_range(14, 40);
				else len = $urandom_range(41, 150);
				// keep the phase near its byte budget
				if (len > target - sent) len = target - sent;
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 9) == 0) send_byte(any_nonletter(), 1'b0);
					send_byte(c, 1'b0);
				end
				sent += len;
			end else begin
				// close the stream on a non-letter, the same letter or a new one
				r = $urandom_range(0, 2);
				if (r == 0) send_byte(any_nonletter(), 1'b1);
				else if (r == 1) send_byte(pend_on ? pend_letter : any_letter(), 1'b1);
				else send_byte(any_letter(), 1'b1);
				sent++;
			end
		end
		send_byte(any_nonletter(), 1'b1);
	endtask

	task automatic test_random_streams();
		logic [THR_W-1:0] thr_list[9];
		thr_list = '{5'd2, 5'd5, 5'd16, 5'd0, 5'd13, 5'd31, 5'd1, 5'd12, 5'd9};
		foreach (thr_list[i]) begin
			write_threshold(i == 8 ? THR_W'($urandom_range(0, 31)) : thr_list[i]);
			send_idle = (i % 3) != 2;
			rcv_idle = (i % 4) != 3;
			random_stream_phase(22);
		end
		send_idle = 1'b1;
		rcv_idle = 1'b1;
	endtask

	task automatic finish_run();
		drain_all();
		if (err_count == 0)
			$display("letter_run_length_encoder_core verification clean");
		else
			$display("letter_run_length_encoder_core verification failed");
		$finish;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_run_breaks();
		test_bare_end();
		test_letter_edges();
		test_long_run();
		test_random_streams();
		finish_run();
	end

endmodule
